// File: hdl/utf8_stream_sanitizer_assert.svh
// Assertion macros for the UTF-8 stream sanitiser checks.
// Included by the checker module; needs no package.
`ifndef UTF8_STREAM_SANITIZER_ASSERT_SVH
`define UTF8_STREAM_SANITIZER_ASSERT_SVH

// same-cycle implication
`define U8S_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define U8S_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/utf8s_pkg.sv
// Shared types, byte constants and the expansion-length function of the
// UTF-8 stream sanitiser. No dependencies.
package utf8s_pkg;

	localparam int NumSlots = 4;
	localparam int SlotIdxW = $clog2(NumSlots);

	typedef enum logic [1:0] {
		SK_NONE,
		SK_RAW,
		SK_LATIN,
		SK_FRESH
	} slot_kind_t;

	typedef struct packed {
		slot_kind_t  kind;
		logic [7:0]  data;
	} slot_t;

	localparam logic [7:0] ByteTab     = 8'd9;
	localparam logic [7:0] ByteLf      = 8'd10;
	localparam logic [7:0] ByteCr      = 8'd13;
	localparam logic [7:0] ByteSpace   = 8'd32;
	localparam logic [7:0] ByteDel     = 8'd127;
	localparam logic [7:0] ByteEuroIn  = 8'd128;
	localparam logic [7:0] ByteNel     = 8'd133;
	localparam logic [7:0] ByteNbsp    = 8'd160;
	localparam logic [7:0] ByteContLo  = 8'd128;
	localparam logic [7:0] ByteContEnd = 8'd192;
	localparam logic [7:0] ByteC2      = 8'd194;
	localparam logic [7:0] ByteC3      = 8'd195;
	localparam logic [7:0] Byte3Lead   = 8'd224;
	localparam logic [7:0] Byte4Lead   = 8'd240;
	localparam logic [7:0] ByteBadLead = 8'd245;
	localparam logic [7:0] EuroB0      = 8'd226;
	localparam logic [7:0] EuroB1      = 8'd130;
	localparam logic [7:0] EuroB2      = 8'd172;
	localparam logic [7:0] Latin1Off   = 8'd64;

	// Number of bytes a slot expands to (0..3).
	function automatic logic [1:0] slot_len(slot_t s, logic last);
		logic [7:0] c;
		logic [1:0] len;
		c   = s.data;
		len = 2'd0;
		unique case (s.kind)
			SK_NONE:  len = 2'd0;
			SK_RAW:   len = 2'd1;
			SK_LATIN: len = 2'd2;
			SK_FRESH: begin
				if (c < ByteSpace) begin
					len = (c == ByteTab || c == ByteLf || c == ByteCr) ? 2'd1 : 2'd0;
				end else if (c < ByteDel) begin
					len = 2'd1;
				end else if (c < ByteNbsp) begin
					len = (c == ByteEuroIn) ? 2'd3 : ((c == ByteNel) ? 2'd2 : 2'd0);
				end else if (c < ByteC2) begin
					len = 2'd2;
				end else if (c < ByteBadLead) begin
					len = last ? 2'd2 : 2'd0;
				end else begin
					len = 2'd2;
				end
			end
			default: len = 2'd0;
		endcase
		return len;
	endfunction

endpackage

// File: hdl/utf8s_expand.sv
// Shared byte generator: gives byte number pos of one slot's expansion.
// Depends on utf8s_pkg.
module utf8s_expand import utf8s_pkg::*; (
	input  slot_t       slot,
	input  logic [1:0]  pos,
	input  logic        last,
	output logic [1:0]  len,
	output logic [7:0]  data
);

	logic [7:0] c;

	assign c   = slot.data;
	assign len = slot_len(slot, last);

	always_comb begin
		data = c;
		unique case (slot.kind)
			SK_NONE:  data = c;
			SK_RAW:   data = c;
			SK_LATIN: data = (pos == 2'd0) ? ByteC3 : c - Latin1Off;
			SK_FRESH: begin
				if (c < ByteDel) begin
					data = c;
				end else if (c == ByteEuroIn) begin
					data = (pos == 2'd0) ? EuroB0 : ((pos == 2'd1) ? EuroB1 : EuroB2);
				end else if (c == ByteNel) begin
					data = (pos == 2'd0) ? ByteLf : ByteCr;
				end else if (c >= ByteNbsp && c < ByteContEnd) begin
					data = (pos == 2'd0) ? ByteC2 : c;
				end else begin
					// Latin-1 recode
					data = (pos == 2'd0) ? ByteC3 : c - Latin1Off;
				end
			end
			default: data = c;
		endcase
	end

endmodule

// File: hdl/utf8_stream_sanitizer.sv
// Top level of the UTF-8 stream sanitiser: slot loader, sequencer and
// output register. Depends on utf8s_pkg and utf8s_expand.
//
//   channel | signals                                   | dir
//   in      | in_valid in_ready in_byte is_last         | sink
//   out     | out_valid out_ready out_byte byte_valid   | source
//           |   string_end run_last                     |
//
// An item is taken into up to four slots; the sequencer then walks the
// slots through the shared byte generator, one output byte per cycle while
// the output register is free or being taken, stepping over each empty slot
// ahead of a later non-empty one. in_ready is low while an item is in work.
// Reset clears the sequence state; no clearing pass.
module utf8_stream_sanitizer import utf8s_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        string_end,
	output logic        run_last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_MARK
	} state_t;

	state_t                state_q;
	slot_t                 slots_q [NumSlots];
	logic [SlotIdxW-1:0]   slot_idx_q;
	logic [1:0]            pos_q;
	logic                  last_q;
	logic [7:0]            lead_q;
	logic [1:0]            need_q;
	logic [1:0]            held_q;
	logic [7:0]            buf_q [2];

	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  byte_valid_q;
	logic                  string_end_q;
	logic                  run_last_q;

	slot_t                 nslots [NumSlots];
	logic [7:0]            n_lead;
	logic [1:0]            n_need;
	logic [1:0]            n_held;
	logic                  buf_we;
	logic                  is_cont;
	logic                  is_lead;
	logic [1:0]            lead_class;
	logic                  completes;

	logic [1:0]            lens [NumSlots];
	logic                  later_nz;
	logic                  rest_nz;
	logic [1:0]            cur_len;
	logic [7:0]            cur_byte;
	logic                  out_free;
	logic                  out_load;
	logic                  in_acc;
	logic                  pos_end;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign string_end = string_end_q;
	assign run_last   = run_last_q;
	assign out_free   = !out_valid_q || out_ready;

	// a new output item goes into the register this cycle
	assign out_load = out_free && ((state_q == ST_RUN && rest_nz && cur_len != 2'd0) ||
		state_q == ST_MARK);

	// Decode the incoming item into slots and the next sequence state
	always_comb begin
		for (int k = 0; k < NumSlots; k++) begin
			nslots[k] = '{kind: SK_NONE, data: 8'd0};
		end
		is_cont    = (in_byte >= ByteContLo) && (in_byte < ByteContEnd);
		is_lead    = (in_byte >= ByteC2) && (in_byte < ByteBadLead);
		lead_class = (in_byte < Byte3Lead) ? 2'd1 : ((in_byte < Byte4Lead) ? 2'd2 : 2'd3);
		completes  = ({1'b0, held_q} + 3'd1) >= {1'b0, need_q};
		n_lead     = lead_q;
		n_need     = need_q;
		n_held     = held_q;
		buf_we     = 1'b0;
		if (need_q == 2'd0) begin
			nslots[0] = '{kind: SK_FRESH, data: in_byte};
			if (is_lead && !is_last) begin
				n_lead = in_byte;
				n_need = lead_class;
				n_held = 2'd0;
			end
		end else if (is_cont && completes) begin
			n_need = 2'd0;
			n_held = 2'd0;
			// C2 followed by a C1 control: whole pair dropped
			if (!(lead_q == ByteC2 && need_q == 2'd1 && in_byte < ByteNbsp)) begin
				nslots[0] = '{kind: SK_RAW, data: lead_q};
				if (held_q >= 2'd1) nslots[1] = '{kind: SK_RAW, data: buf_q[0]};
				if (held_q >= 2'd2) nslots[2] = '{kind: SK_RAW, data: buf_q[1]};
				nslots[3] = '{kind: SK_RAW, data: in_byte};
			end
		end else if (is_cont && !is_last) begin
			buf_we = 1'b1;
			n_held = held_q + 2'd1;
		end else begin
			// broken or cut sequence: recode lead, replay held bytes singly
			n_need    = 2'd0;
			n_held    = 2'd0;
			nslots[0] = '{kind: SK_LATIN, data: lead_q};
			if (held_q >= 2'd1) nslots[1] = '{kind: SK_FRESH, data: buf_q[0]};
			if (held_q >= 2'd2) nslots[2] = '{kind: SK_FRESH, data: buf_q[1]};
			nslots[3] = '{kind: SK_FRESH, data: in_byte};
			if (!is_cont && is_lead && !is_last) begin
				n_lead = in_byte;
				n_need = lead_class;
				n_held = 2'd0;
			end
		end
	end

	// Look ahead over the slots to find the final byte of the item
	always_comb begin
		later_nz = 1'b0;
		rest_nz  = 1'b0;
		for (int k = 0; k < NumSlots; k++) begin
			lens[k] = slot_len(slots_q[k], last_q);
			if (SlotIdxW'(k) > slot_idx_q && lens[k] != 2'd0) later_nz = 1'b1;
			if (SlotIdxW'(k) >= slot_idx_q && lens[k] != 2'd0) rest_nz = 1'b1;
		end
	end

	utf8s_expand u_expand (
		.slot (slots_q[slot_idx_q]),
		.pos  (pos_q),
		.last (last_q),
		.len  (cur_len),
		.data (cur_byte)
	);

	assign pos_end = (pos_q == cur_len - 2'd1);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int k = 0; k < NumSlots; k++) begin
				slots_q[k] <= nslots[k];
			end
			if (buf_we) begin
				buf_q[held_q[0]] <= in_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_idx_q   <= '0;
			pos_q        <= 2'd0;
			last_q       <= 1'b0;
			lead_q       <= 8'd0;
			need_q       <= 2'd0;
			held_q       <= 2'd0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= 8'd0;
			byte_valid_q <= 1'b0;
			string_end_q <= 1'b0;
			run_last_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q    <= ST_RUN;
						slot_idx_q <= '0;
						pos_q      <= 2'd0;
						last_q     <= is_last;
						lead_q     <= n_lead;
						need_q     <= n_need;
						held_q     <= n_held;
					end
				end
				ST_RUN: begin
					if (!rest_nz) begin
						state_q <= last_q ? ST_MARK : ST_IDLE;
					end else if (cur_len == 2'd0) begin
						slot_idx_q <= slot_idx_q + 1'b1;
						pos_q      <= 2'd0;
					end else if (out_free) begin
						out_byte_q   <= cur_byte;
						byte_valid_q <= 1'b1;
						run_last_q   <= pos_end && !later_nz;
						string_end_q <= pos_end && !later_nz && last_q;
						if (pos_end) begin
							pos_q <= 2'd0;
							if (!later_nz) begin
								state_q <= ST_IDLE;
							end else begin
								slot_idx_q <= slot_idx_q + 1'b1;
							end
						end else begin
							pos_q <= pos_q + 2'd1;
						end
					end
				end
				ST_MARK: begin
					// empty end-of-string marker
					if (out_free) begin
						out_byte_q   <= 8'd0;
						byte_valid_q <= 1'b0;
						run_last_q   <= 1'b1;
						string_end_q <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/utf8s_checker.sv
// Port-level checks for the UTF-8 stream sanitiser, bound to the top level.
// Depends on utf8_stream_sanitizer_assert.svh.
`include "utf8_stream_sanitizer_assert.svh"

module utf8s_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        byte_valid,
	input logic        string_end,
	input logic        run_last
);

	`U8S_ASSERT_IMP(a_marker_form, clk, arst_n, out_valid && !byte_valid, string_end && run_last && out_byte == 8'd0, "empty item is not a clean end marker")
	`U8S_ASSERT_IMP(a_end_is_run_last, clk, arst_n, out_valid && string_end, run_last, "string end without run end")
	`U8S_ASSERT_NXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready, "input taken while an item is in work")
	`U8S_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(run_last), "stalled output item changed")

endmodule

bind utf8_stream_sanitizer utf8s_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_byte   (out_byte),
	.byte_valid (byte_valid),
	.string_end (string_end),
	.run_last   (run_last)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_stream_sanitizer: directed table then random byte strings,
// every output item checked against an in-bench sanitiser model or typed-in bytes.
// Depends on utf8s_pkg and the utf8_stream_sanitizer RTL.
module tb_top;
	import utf8s_pkg::*;

	localparam int MaxResults  = 10;
	localparam int StallLimit  = 3000;
	localparam int DrainCycles = 20;
	localparam int PhaseItems  = 32;
	localparam int NumRows     = 26;

	typedef struct packed {
		logic [7:0]  data;
		logic        valid;
		logic        send;
		logic        rlast;
	} clean_item_t;

	// lit set: expected bytes are typed in (n of them, msb first), not predicted
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        lit;
		logic [1:0]  n;
		logic [23:0] bytes;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'd0;
	logic        is_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        string_end;
	logic        run_last;

	// literal expectation travelling with the item on the input channel
	logic        lit_on = 1'b0;
	logic [1:0]  lit_n = 2'd0;
	logic [23:0] lit_bytes = 24'd0;

	int          send_idle_pct = 14;
	int          recv_idle_pct = 63;
	int          mismatches = 0;
	int          stall_cycles = 0;

	// sanitiser model state
	logic [7:0]  seq_lead;
	logic [1:0]  seq_need;
	logic [1:0]  seq_held;
	logic [7:0]  seq_cont [2];
	logic [7:0]  step_bytes [$];
	clean_item_t clean_stream_q [$];
	logic [7:0]  frag_q [$];

	dir_row_t dir_rows [NumRows] = '{
		'{8'd0,   1'b1, 1'b1, 2'd0, 24'h000000},
		'{8'd9,   1'b0, 1'b1, 2'd1, 24'h090000},
		'{8'd10,  1'b0, 1'b1, 2'd1, 24'h0A0000},
		'{8'd13,  1'b0, 1'b1, 2'd1, 24'h0D0000},
		'{8'd31,  1'b0, 1'b1, 2'd0, 24'h000000},
		'{8'd126, 1'b0, 1'b1, 2'd1, 24'h7E0000},
		'{8'd127, 1'b0, 1'b1, 2'd0, 24'h000000},
		'{8'd128, 1'b0, 1'b1, 2'd3, 24'hE282AC},
		'{8'd133, 1'b0, 1'b1, 2'd2, 24'h0A0D00},
		'{8'd159, 1'b0, 1'b1, 2'd0, 24'h000000},
		'{8'd160, 1'b0, 1'b1, 2'd2, 24'hC2A000},
		'{8'd193, 1'b0, 1'b1, 2'd2, 24'hC38100},
		'{8'd255, 1'b1, 1'b1, 2'd2, 24'hC3BF00},
		// C2 followed by a C1 control: both dropped
		'{8'd194, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'd159, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'd226, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'd130, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'd172, 1'b0, 1'b0, 2'd0, 24'h000000},
		// four-byte lead broken by ASCII after two continuations
		'{8'd240, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'd144, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'd128, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'd65,  1'b0, 1'b0, 2'd0, 24'h000000},
		// sequence cut short by end of string
		'{8'd240, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'd161, 1'b0, 1'b0, 2'd0, 24'h000000},
		'{8'd162, 1'b1, 1'b0, 2'd0, 24'h000000},
		'{8'd244, 1'b1, 1'b0, 2'd0, 24'h000000}
	};

	utf8_stream_sanitizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.string_end (string_end),
		.run_last   (run_last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void put_byte(logic [7:0] b);
		if (step_bytes.size() < MaxResults) begin
			step_bytes.push_back(b);
		end
	endfunction

	function automatic void put_latin(logic [7:0] b);
		put_byte(ByteC3);
		put_byte(b - Latin1Off);
	endfunction

	// byte with no sequence pending; a lead opens one unless it ends the string
	function automatic void lone_byte(logic [7:0] c, logic last);
		if (c < ByteSpace) begin
			if (c == ByteTab || c == ByteLf || c == ByteCr) begin
				put_byte(c);
			end
		end else if (c < ByteDel) begin
			put_byte(c);
		end else if (c < ByteNbsp) begin
			if (c == ByteEuroIn) begin
				put_byte(EuroB0);
				put_byte(EuroB1);
				put_byte(EuroB2);
			end else if (c == ByteNel) begin
				put_byte(ByteLf);
				put_byte(ByteCr);
			end
		end else if (c < ByteContEnd) begin
			put_byte(ByteC2);
			put_byte(c);
		end else if (c < ByteC2) begin
			put_latin(c);
		end else if (c < ByteBadLead) begin
			if (last) begin
				put_latin(c);
			end else begin
				seq_lead = c;
				seq_need = (c < Byte3Lead) ? 2'd1 : ((c < Byte4Lead) ? 2'd2 : 2'd3);
				seq_held = 2'd0;
			end
		end else begin
			put_latin(c);
		end
	endfunction

	// recode the lead as Latin-1 and replay the held continuations singly
	function automatic void drop_seq();
		int held;
		held = seq_held;
		put_latin(seq_lead);
		seq_need = 2'd0;
		seq_held = 2'd0;
		for (int k = 0; k < held && k < 2; k++) begin
			lone_byte(seq_cont[k], 1'b0);
		end
	endfunction

	function automatic void sanitize_byte(logic [7:0] b, logic last);
		step_bytes.delete();
		if (seq_need == 2'd0) begin
			lone_byte(b, last);
		end else if (b >= ByteContLo && b < ByteContEnd) begin
			if (int'(seq_held) + 1 >= int'(seq_need)) begin
				if (!(seq_lead == ByteC2 && seq_need == 2'd1 && b < ByteNbsp)) begin
					put_byte(seq_lead);
					for (int k = 0; k < int'(seq_held) && k < 2; k++) begin
						put_byte(seq_cont[k]);
					end
					put_byte(b);
				end
				seq_need = 2'd0;
				seq_held = 2'd0;
			end else if (last) begin
				drop_seq();
				lone_byte(b, 1'b1);
			end else begin
				seq_cont[seq_held[0]] = b;
				seq_held = seq_held + 2'd1;
			end
		end else begin
			drop_seq();
			lone_byte(b, last);
		end
	endfunction

	// turn this item's bytes into expected output items; empty end marker if none and it ends the string
	function automatic void queue_clean_items(logic last);
		clean_item_t it;
		int n;
		n = step_bytes.size();
		if (n == 0 && last) begin
			clean_stream_q.push_back('{8'd0, 1'b0, 1'b1, 1'b1});
		end
		for (int k = 0; k < n; k++) begin
			it.data  = step_bytes[k];
			it.valid = 1'b1;
			it.rlast = (k == n - 1);
			it.send  = (k == n - 1) && last;
			clean_stream_q.push_back(it);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// predict on input acceptance first, then check the output item of the same edge
	always @(posedge clk or negedge arst_n) begin
		clean_item_t want;
		clean_item_t got;
		if (!arst_n) begin
			seq_lead <= 8'd0;
			seq_need <= 2'd0;
			seq_held <= 2'd0;
			stall_cycles <= 0;
		end else begin
			if (in_valid && in_ready) begin
				sanitize_byte(in_byte, is_last);
				if (lit_on) begin
					step_bytes.delete();
					for (int k = 0; k < int'(lit_n); k++) begin
						step_bytes.push_back(lit_bytes[23 - 8 * k -: 8]);
					end
				end
				queue_clean_items(is_last);
			end
			if (out_valid && out_ready) begin
				got = '{out_byte, byte_valid, string_end, run_last};
				if (clean_stream_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected out item: byte %02h valid %0b end %0b run_last %0b",
							got.data, got.valid, got.send, got.rlast);
					end
				end else begin
					want = clean_stream_q.pop_front();
					if (got.data !== want.data || got.valid !== want.valid ||
							got.send !== want.send || got.rlast !== want.rlast) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("out item: want %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
								want.data, want.valid, want.send, want.rlast,
								got.data, got.valid, got.send, got.rlast);
						end
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		while (stall_cycles < StallLimit) begin
			@(posedge clk);
		end
		$display("utf8_stream_sanitizer: mismatch");
		$finish;
	end

	// called at a rising edge; leaves in_valid high on return
	task automatic send_item(logic [7:0] b, logic last, logic lit, logic [1:0] n,
			logic [23:0] bytes);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		in_byte   <= b;
		is_last   <= last;
		lit_on    <= lit;
		lit_n     <= n;
		lit_bytes <= bytes;
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	// one piece of a string: a random byte, an ASCII byte, or a (maybe truncated) sequence
	function automatic void make_fragment();
		int pick;
		int len;
		int keep;
		logic [7:0] lead;
		frag_q.delete();
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			frag_q.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 40) begin
			frag_q.push_back(8'($urandom_range(0, 127)));
		end else begin
			len = $urandom_range(2, 4);
			case (len)
				2: begin
					lead = ($urandom_range(0, 2) == 0) ? ByteC2 : 8'($urandom_range(194, 223));
				end
				3: begin
					lead = 8'($urandom_range(224, 239));
				end
				default: begin
					lead = 8'($urandom_range(240, 244));
				end
			endcase
			frag_q.push_back(lead);
			keep = (pick < 85) ? len : $urandom_range(1, len - 1);
			for (int k = 1; k < keep; k++) begin
				frag_q.push_back(8'($urandom_range(128, 191)));
			end
		end
	endfunction

	initial begin
		int sent;
		logic ends_string;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			send_item(dir_rows[r].data, dir_rows[r].last, dir_rows[r].lit, dir_rows[r].n,
				dir_rows[r].bytes);
		end

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 14;
					recv_idle_pct = 63;
				end
				1: begin
					send_idle_pct = 63;
					recv_idle_pct = 14;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < PhaseItems) begin
				make_fragment();
				ends_string = ($urandom_range(0, 4) == 0);
				foreach (frag_q[k]) begin
					send_item(frag_q[k], ends_string && (k == frag_q.size() - 1), 1'b0, 2'd0,
						24'd0);
					sent++;
				end
			end
		end
		in_valid <= 1'b0;

		while (clean_stream_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0 && clean_stream_q.size() == 0) begin
			$display("utf8_stream_sanitizer: match");
		end else begin
			$display("utf8_stream_sanitizer: mismatch");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/utf8s_pkg.sv
hdl/utf8s_expand.sv
hdl/utf8_stream_sanitizer.sv
hdl/utf8s_checker.sv
tb/tb_top.sv
